// ----- hw/rtl/sorted_list_insert_remove_macros.svh -----
// Assertion macros shared by the sorted list insert/remove RTL.
`ifndef SORTED_LIST_INSERT_REMOVE_MACROS_SVH
`define SORTED_LIST_INSERT_REMOVE_MACROS_SVH

// Property checked at every clock edge outside reset.
`define SLIR_ASSERT(name, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define SLIR_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/slir_pkg.sv -----
// Shared types and constants for the sorted list insert/remove block.
package slir_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int VALUE_W      = 32;
    localparam int COUNT_OUT_W  = 5;
    localparam int OUT_DATA_W   = 8;

    // Request kinds
    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } t_op;

    // Controller states
    typedef enum logic {
        ST_IDLE   = 1'b0,
        ST_UPDATE = 1'b1
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;    // latch request and register per-cell compare flags
        logic commit;  // shift the row, update count, load result register
    } t_dp_cmd;

endpackage

// ----- hw/rtl/slir_dp.sv -----
// Datapath: row of sorted entry cells, fill count and result register.
`include "sorted_list_insert_remove_macros.svh"

module slir_dp #(
    parameter int CAPACITY = slir_pkg::CAPACITY_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  slir_pkg::t_dp_cmd                   i_cmd,
    input  slir_pkg::t_op                       i_op,
    input  logic signed [slir_pkg::VALUE_W-1:0] i_value,
    output logic [slir_pkg::OUT_DATA_W-1:0]     o_out_data
);

    localparam int CntW = $clog2(CAPACITY + 1);

    slir_pkg::t_op                       r_op;
    logic signed [slir_pkg::VALUE_W-1:0] r_value;
    logic signed [slir_pkg::VALUE_W-1:0] r_entries [CAPACITY];
    logic signed [slir_pkg::VALUE_W-1:0] n_entries [CAPACITY];
    logic [CAPACITY-1:0]                 r_le, r_lt, r_eq;
    logic [CAPACITY-1:0]                 n_le, n_lt, n_eq;
    logic [CntW-1:0]                     r_count, n_count;
    logic [slir_pkg::OUT_DATA_W-1:0]     r_out_data, n_out_data;
    logic                                w_found, w_full, w_do_ins, w_do_rem;
    logic                                w_ins_blocked;

    // Per-cell compare against the incoming value (cells at or above count are off)
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            n_le[i] = (r_count > CntW'(i)) && (r_entries[i] <= i_value);
            n_lt[i] = (r_count > CntW'(i)) && (r_entries[i] <  i_value);
            n_eq[i] = (r_count > CntW'(i)) && (r_entries[i] == i_value);
        end
    end

    // Request latch and compare flags
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_op;
            r_value <= i_value;
            r_le    <= n_le;
            r_lt    <= n_lt;
            r_eq    <= n_eq;
        end
    end

    // Decision from the registered flags
    assign w_found       = |r_eq;
    assign w_full        = (r_count == CntW'(CAPACITY));
    assign w_do_ins      = (r_op == slir_pkg::OP_INSERT) && !w_full;
    assign w_do_rem      = (r_op == slir_pkg::OP_REMOVE) && w_found;
    assign w_ins_blocked = (r_op == slir_pkg::OP_INSERT) && w_full;

    // Next value of each cell: insert shifts up past the last <= entry,
    // remove pulls down from the first entry that is not < value
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            n_entries[i] = r_entries[i];
            if (w_do_ins && !r_le[i]) begin
                if (i == 0) begin
                    n_entries[i] = r_value;
                end else if (r_le[(i == 0) ? 0 : i-1]) begin
                    n_entries[i] = r_value;
                end else begin
                    n_entries[i] = r_entries[(i == 0) ? 0 : i-1];
                end
            end else if (w_do_rem && !r_lt[i]) begin
                if (i < CAPACITY - 1) begin
                    n_entries[i] = r_entries[(i < CAPACITY - 1) ? i+1 : i];
                end
            end
        end
    end

    // Count and result word
    always_comb begin
        n_count = r_count;
        if (w_do_ins) begin
            n_count = r_count + CntW'(1);
        end else if (w_do_rem) begin
            n_count = r_count - CntW'(1);
        end
        n_out_data = {n_count == CntW'(CAPACITY),
                      n_count == '0,
                      slir_pkg::COUNT_OUT_W'(n_count),
                      w_do_ins || w_do_rem};
    end

    // Cell row and result register (payload, no reset)
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_entries  <= n_entries;
            r_out_data <= n_out_data;
        end
    end

    // Fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.commit) begin
            r_count <= n_count;
        end
    end

    assign o_out_data = r_out_data;

    `SLIR_ASSERT(a_count_range, r_count <= CntW'(CAPACITY), "fill count above capacity")
    `SLIR_ASSERT_NEXT(a_count_hold, !i_cmd.commit, $stable(r_count), "count moved without commit")
    `SLIR_ASSERT_NEXT(a_ins_full, i_cmd.commit && w_ins_blocked, w_full, "full insert changed count")

endmodule

// ----- hw/rtl/slir_ctrl.sv -----
// Controller: request handshake, two-step sequencing and result valid.
`include "sorted_list_insert_remove_macros.svh"

module slir_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output slir_pkg::t_dp_cmd o_cmd
);

    slir_pkg::t_state r_state, n_state;
    logic             r_out_valid, n_out_valid;
    logic             w_accept, w_commit;

    assign w_accept = i_s_tvalid && (r_state == slir_pkg::ST_IDLE);
    assign w_commit = (r_state == slir_pkg::ST_UPDATE) && (!r_out_valid || i_m_tready);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            slir_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_state = slir_pkg::ST_UPDATE;
                end
            end
            slir_pkg::ST_UPDATE: begin
                if (w_commit) begin
                    n_state = slir_pkg::ST_IDLE;
                end
            end
            default: n_state = slir_pkg::ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_s_tready   = 1'b0;
        o_cmd.load   = 1'b0;
        o_cmd.commit = 1'b0;
        unique case (r_state)
            slir_pkg::ST_IDLE: begin
                o_s_tready = 1'b1;
                o_cmd.load = w_accept;
            end
            slir_pkg::ST_UPDATE: begin
                o_cmd.commit = w_commit;
            end
            default: begin
                o_s_tready = 1'b0;
            end
        endcase
    end

    // Result valid: set on commit, cleared when the word is taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (w_commit) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= slir_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_m_tvalid = r_out_valid;

    `SLIR_ASSERT_NEXT(a_load_to_update, o_cmd.load, r_state == slir_pkg::ST_UPDATE, "load did not enter update")
    `SLIR_ASSERT_NEXT(a_commit_valid, o_cmd.commit, o_m_tvalid, "commit gave no result")
    `SLIR_ASSERT(a_no_overwrite, !(o_cmd.commit && r_out_valid && !i_m_tready), "pending result overwritten")

endmodule

// ----- hw/rtl/sorted_list_insert_remove.sv -----
// Sorted list insert/remove: keeps up to CAPACITY signed 32-bit values in
// ascending order. The cycle a request is accepted compares the value with
// every cell of the row at once and registers the flags; the update step
// then shifts the row up (insert, after equal entries, if not full) or down
// (remove, first equal entry, if found) and loads the result word. No new
// request is accepted until that update is done. The result sits in an output
// register, so a new request is taken while it waits; if it is still not
// taken when the following shift is due, that shift waits for it. Entry
// contents are not reset; only the fill count is.
module sorted_list_insert_remove #(
    parameter int CAPACITY = slir_pkg::CAPACITY_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [slir_pkg::VALUE_W-1:0]      i_s_tdata,   // [31:0] value (signed)
    input  logic                              i_s_tuser,   // [0] op: 0 insert, 1 remove
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [slir_pkg::OUT_DATA_W-1:0]   o_m_tdata    // [0] ok, [5:1] count,
                                                           // [6] is_empty, [7] is_full
);

    slir_pkg::t_dp_cmd w_cmd;

    slir_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_cmd      (w_cmd)
    );

    slir_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_op       (slir_pkg::t_op'(i_s_tuser)),
        .i_value    ($signed(i_s_tdata)),
        .o_out_data (o_m_tdata)
    );

endmodule

// ----- verif/sorted_list_insert_remove_tb.sv -----
// Self-checking testbench: random insert/remove requests checked against a shadow list.
`timescale 1ns / 1ps

module sorted_list_insert_remove_tb;

    localparam int CAPACITY  = slir_pkg::CAPACITY_DEF;
    localparam int TAIL_CYC  = 20;
    localparam int PHASES    = 13;
    localparam int PHASE_LEN = 50;
    localparam int POOL_SIZE = 12;

    // One request word as queued for the driver; hold marks a pause until drained
    typedef struct {
        bit                                 hold;
        slir_pkg::t_op                      op;
        logic [slir_pkg::VALUE_W-1:0]       value;
    } t_request;

    // Result word layout, lowest bit last
    typedef struct packed {
        logic                               is_full;
        logic                               is_empty;
        logic [slir_pkg::COUNT_OUT_W-1:0]   count;
        logic                               ok;
    } t_status;

    logic                                i_clk;
    logic                                i_rst_n    = 1'b0;
    logic                                i_s_tvalid = 1'b0;
    logic                                o_s_tready;
    logic [slir_pkg::VALUE_W-1:0]        i_s_tdata  = '0;   // [31:0] value (signed)
    logic                                i_s_tuser  = 1'b0; // [0] op: 0 insert, 1 remove
    logic                                o_m_tvalid;
    logic                                i_m_tready = 1'b0;
    logic [slir_pkg::OUT_DATA_W-1:0]     o_m_tdata;  // [0] ok, [5:1] count, [6] empty, [7] full

    t_request                            request_q[$];
    t_status                             expected_status_q[$];
    int                                  error_count = 0;

    // Shadow copy of the list
    logic signed [slir_pkg::VALUE_W-1:0] shadow_vals [CAPACITY];
    int                                  shadow_fill = 0;

    // Handshake flags seen at the last rising edge
    logic                                word_taken   = 1'b0;
    logic                                status_taken = 1'b0;

    // Idle control
    int                                  src_gap      = 0;
    int                                  snk_gap      = 0;
    int                                  stretch_left = 0;
    bit                                  calm         = 1'b0;

    sorted_list_insert_remove #(.CAPACITY(CAPACITY)) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Apply one request to the shadow list and return the status it yields
    function automatic t_status apply_request(slir_pkg::t_op op,
                                              logic signed [slir_pkg::VALUE_W-1:0] v);
        t_status st;
        int      pos;
        int      k;
        pos = 0;
        st  = '0;
        if (op == slir_pkg::OP_INSERT) begin
            if (shadow_fill < CAPACITY) begin
                // goes after every entry <= v
                while (pos < shadow_fill && shadow_vals[pos] <= v) pos++;
                for (k = shadow_fill; k > pos; k--) shadow_vals[k] = shadow_vals[k-1];
                shadow_vals[pos] = v;
                shadow_fill++;
                st.ok = 1'b1;
            end
        end else if (shadow_fill > 0) begin
            // first entry not below v must equal it
            while (pos < shadow_fill && shadow_vals[pos] < v) pos++;
            if (pos < shadow_fill && shadow_vals[pos] == v) begin
                for (k = pos + 1; k < shadow_fill; k++) shadow_vals[k-1] = shadow_vals[k];
                shadow_fill--;
                st.ok = 1'b1;
            end
        end
        st.count    = slir_pkg::COUNT_OUT_W'(shadow_fill);
        st.is_empty = (shadow_fill == 0);
        st.is_full  = (shadow_fill == CAPACITY);
        return st;
    endfunction

    task automatic push_request(slir_pkg::t_op op, logic [slir_pkg::VALUE_W-1:0] v);
        t_request r;
        r.hold  = 1'b0;
        r.op    = op;
        r.value = v;
        request_q.push_back(r);
    endtask

    task automatic push_hold();
        t_request r;
        r.hold  = 1'b1;
        r.op    = slir_pkg::OP_INSERT;
        r.value = '0;
        request_q.push_back(r);
    endtask

    // Driver and sink ready, all changes at the falling edge
    always @(negedge i_clk) begin
        t_request nxt;
        if (i_rst_n) begin
            // alternate stretches with and without idling
            if (stretch_left == 0) begin
                calm         = ($urandom_range(0, 3) == 0);
                stretch_left = $urandom_range(16, 64);
            end else begin
                stretch_left--;
            end

            // source side
            if (!(i_s_tvalid && !word_taken)) begin
                if (i_s_tvalid && word_taken) src_gap = calm ? 0 : $urandom_range(0, 4);
                if (src_gap > 0) begin
                    src_gap--;
                    i_s_tvalid <= 1'b0;
                end else if (request_q.size() > 0 && request_q[0].hold) begin
                    if (expected_status_q.size() == 0) request_q.delete(0);
                    i_s_tvalid <= 1'b0;
                end else if (request_q.size() > 0) begin
                    nxt = request_q.pop_front();
                    i_s_tvalid <= 1'b1;
                    i_s_tdata  <= nxt.value;
                    i_s_tuser  <= nxt.op;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end

            // sink side
            if (i_m_tready && status_taken) snk_gap = calm ? 0 : $urandom_range(0, 4);
            if (snk_gap > 0) begin
                snk_gap--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // Monitor: predict on accepted requests, check accepted results
    always @(posedge i_clk) begin
        t_status got;
        t_status want;
        word_taken   <= i_rst_n && i_s_tvalid && o_s_tready;
        status_taken <= i_rst_n && o_m_tvalid && i_m_tready;
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready)
                expected_status_q.push_back(
                    apply_request(slir_pkg::t_op'(i_s_tuser), i_s_tdata));
            if (o_m_tvalid && i_m_tready) begin
                got = t_status'(o_m_tdata);
                if (expected_status_q.size() == 0) begin
                    $display("%0t: unexpected status word, expected none, actual %h",
                             $time, o_m_tdata);
                    error_count++;
                end else begin
                    want = expected_status_q.pop_front();
                    if (got !== want) begin
                        $display("%0t: status mismatch: expected ok=%0b count=%0d ",
                                 $time, want.ok, want.count,
                                 "empty=%0b full=%0b, ", want.is_empty, want.is_full,
                                 "actual ok=%0b count=%0d empty=%0b full=%0b",
                                 got.ok, got.count, got.is_empty, got.is_full);
                        error_count++;
                    end
                end
            end
        end
    end

    // Stimulus and end of run
    initial begin
        logic [slir_pkg::VALUE_W-1:0] value_pool [POOL_SIZE];
        logic [slir_pkg::VALUE_W-1:0] v;
        int                           remove_pct;
        int                           sel;
        int                           p;
        int                           i;

        for (i = 0; i < POOL_SIZE; i++) value_pool[i] = $urandom;

        // directed: remove on empty, extremes, duplicates, absent value
        push_request(slir_pkg::OP_REMOVE, 32'h0000_0005);
        push_request(slir_pkg::OP_INSERT, 32'h7FFF_FFFF);
        push_request(slir_pkg::OP_INSERT, 32'h8000_0000);
        push_request(slir_pkg::OP_INSERT, 32'h0000_0000);
        push_request(slir_pkg::OP_INSERT, 32'h0000_0000);
        push_request(slir_pkg::OP_INSERT, 32'hFFFF_FFFF);
        push_request(slir_pkg::OP_INSERT, 32'h0000_0001);
        push_request(slir_pkg::OP_REMOVE, 32'h0000_0002);
        push_request(slir_pkg::OP_REMOVE, 32'h0000_0000);
        // fill to capacity, then insert when full
        for (i = 0; i < 11; i++) push_request(slir_pkg::OP_INSERT, 32'(i * 3 - 9));
        push_request(slir_pkg::OP_INSERT, 32'h1234_5678);
        push_request(slir_pkg::OP_REMOVE, 32'h7FFF_FFFF);
        push_request(slir_pkg::OP_REMOVE, 32'h8000_0000);
        push_hold();

        // random phases, alternately insert-heavy and remove-heavy
        for (p = 0; p < PHASES; p++) begin
            remove_pct = (p % 2 == 0) ? 25 : 70;
            for (i = 0; i < PHASE_LEN; i++) begin
                sel = $urandom_range(0, 99);
                if (sel < 70)      v = value_pool[$urandom_range(0, POOL_SIZE - 1)];
                else if (sel < 80) begin
                    case ($urandom_range(0, 3))
                        0:       v = 32'h7FFF_FFFF;
                        1:       v = 32'h8000_0000;
                        2:       v = 32'h0000_0000;
                        default: v = 32'hFFFF_FFFF;
                    endcase
                end else           v = $urandom;
                push_request(($urandom_range(0, 99) < remove_pct) ?
                             slir_pkg::OP_REMOVE : slir_pkg::OP_INSERT, v);
            end
            if (p == PHASES / 2) push_hold();
        end

        // hold reset, then release it
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (request_q.size() > 0 || i_s_tvalid || expected_status_q.size() > 0)
            @(posedge i_clk);
        repeat (TAIL_CYC) @(posedge i_clk);

        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #400us;
        $display("Some tests failed");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/slir_pkg.sv
hw/rtl/slir_dp.sv
hw/rtl/slir_ctrl.sv
hw/rtl/sorted_list_insert_remove.sv
verif/sorted_list_insert_remove_tb.sv
